FILE: hdl/chunk_reassembly_tracker_core_macros.svh
// assertion helpers used by the tracker core rtl
// each macro expects aclk and aresetn in scope
`ifndef CHUNK_REASSEMBLY_TRACKER_CORE_MACROS_SVH
`define CHUNK_REASSEMBLY_TRACKER_CORE_MACROS_SVH

// condition holds at every clock edge out of reset
`define CRT_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define CRT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define CRT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/crt_pkg.sv
package crt_pkg;

    localparam int S_DATA_W    = 200;
    localparam int M_DATA_W    = 40;
    localparam int APB_AW      = 3;
    localparam int CHUNK_SHIFT = 10;
    localparam int CHUNK_SIZE  = 1024;
    localparam int MAP_DEPTH   = 512;
    localparam int MAP_AW      = 9;

    // largest transfer the bitmap can cover, in bytes
    localparam logic [19:0] SIZE_CAP      = 20'd524288;
    localparam logic [19:0] MAX_BYTES_RST = 20'd524288;

    // register index carried in paddr[2]
    localparam logic REG_IDX_MAX_BYTES = 1'b0;

    typedef enum logic [1:0] {
        OP_BEGIN = 2'd0,
        OP_CHUNK = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BUSY       = 3'd1,
        ST_TOO_LARGE  = 3'd2,
        ST_UNKNOWN    = 3'd3,
        ST_BAD_CHUNK  = 3'd4,
        ST_NO_PROGRAM = 3'd5
    } status_t;

    typedef struct packed {
        logic              rd_en;
        logic [MAP_AW-1:0] rd_addr;
        logic              wr_en;
        logic [MAP_AW-1:0] wr_addr;
        logic              clr_start;
    } map_req_t;

endpackage

FILE: hdl/crt_map.sv
module crt_map #(
    parameter int EPOCH_W = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  crt_pkg::map_req_t     req,
    input  logic [EPOCH_W-1:0]    wr_tag,
    output logic [EPOCH_W-1:0]    rd_tag,
    output logic                  clearing
);
    import crt_pkg::*;

    logic [EPOCH_W-1:0] mem [MAP_DEPTH];
    logic [EPOCH_W-1:0] rd_tag_reg;
    logic               clr_busy_reg;
    logic [MAP_AW-1:0]  clr_addr_reg;

    // sweep writes zero tags, one entry a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            if (clr_addr_reg == MAP_AW'(MAP_DEPTH - 1)) begin
                clr_busy_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end else if (req.clr_start) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (req.wr_en) begin
            mem[req.wr_addr] <= wr_tag;
        end
    end

    // same-entry write in the read cycle is forwarded
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            if (req.wr_en && !clr_busy_reg && (req.wr_addr == req.rd_addr)) begin
                rd_tag_reg <= wr_tag;
            end else begin
                rd_tag_reg <= mem[req.rd_addr];
            end
        end
    end

    assign rd_tag   = rd_tag_reg;
    assign clearing = clr_busy_reg;

endmodule

FILE: hdl/chunk_reassembly_tracker_core.sv
// a request accepted into stage a is registered into m_tdata when the result register is free
// throughput: one request per cycle without stalls, set by the single bitmap memory read-modify-write
// a begin or clear held in stage a while the epoch is at its top blocks the next request until it commits
// every 2**EPOCH_W-1 epoch advances (taken begin or clear) the bitmap memory is swept, no accepts
// reset: synchronous active-low aresetn clears tracking, sets max_bytes to 524288,
//   then the bitmap memory is swept before the first request is taken
`include "chunk_reassembly_tracker_core_macros.svh"

module chunk_reassembly_tracker_core #(
    parameter int EPOCH_W = 12
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // request channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // xfer_id, byte_total, chunk_total, image_found, chunk_idx, chunk_len, payload_valid
    input  logic [crt_pkg::S_DATA_W-1:0]   s_tdata,
    // op
    input  logic [1:0]                     s_tuser,
    // result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status, write_en, write_offset, complete, seen_count
    output logic [crt_pkg::M_DATA_W-1:0]   m_tdata,
    // register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [crt_pkg::APB_AW-1:0]     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import crt_pkg::*;

    localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;
    localparam logic [EPOCH_W-1:0] EPOCH_ONE = EPOCH_W'(1);

    // ---------------- register port ----------------
    logic [19:0] max_bytes_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[APB_AW-1] == REG_IDX_MAX_BYTES);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_bytes_reg <= MAX_BYTES_RST;
        end else if (cfg_wr) begin
            max_bytes_reg <= pwdata[19:0];
        end
    end

    assign prdata = (paddr[APB_AW-1] == REG_IDX_MAX_BYTES) ? {12'b0, max_bytes_reg} : 32'b0;

    // ---------------- request fields ----------------
    logic [63:0] s_id;
    logic [31:0] s_bytes;
    logic [31:0] s_chunks;
    logic        s_img;
    logic [31:0] s_idx;
    logic [31:0] s_len;
    logic        s_pv;

    assign s_id     = s_tdata[63:0];
    assign s_bytes  = s_tdata[95:64];
    assign s_chunks = s_tdata[127:96];
    assign s_img    = s_tdata[128];
    assign s_idx    = s_tdata[160:129];
    assign s_len    = s_tdata[192:161];
    assign s_pv     = s_tdata[193];

    // checks that need only the request itself are done on the way in
    logic [19:0] size_limit;
    logic [22:0] expect_chunks;
    logic        pre_too_large;
    logic        pre_cnt_bad;
    logic        pre_idx_in;
    logic        pre_len_bad;
    logic        pre_len_full;
    logic [19:0] pre_end;

    assign size_limit    = (max_bytes_reg < SIZE_CAP) ? max_bytes_reg : SIZE_CAP;
    assign pre_too_large = (s_bytes == 32'd0) || (s_bytes > {12'b0, size_limit});
    // rounded-up quotient by the chunk size
    assign expect_chunks = {1'b0, s_bytes[31:CHUNK_SHIFT]} + 23'(|s_bytes[CHUNK_SHIFT-1:0]);
    assign pre_cnt_bad   = (s_chunks != {9'b0, expect_chunks});
    assign pre_idx_in    = (s_idx[31:MAP_AW] == '0);
    assign pre_len_bad   = (s_len == 32'd0) || (s_len > 32'(CHUNK_SIZE));
    assign pre_len_full  = (s_len == 32'(CHUNK_SIZE));
    // end byte of the chunk, only meaningful when index and length are in range
    assign pre_end       = {1'b0, s_idx[MAP_AW-1:0], {CHUNK_SHIFT{1'b0}}}
                           + {9'b0, s_len[CHUNK_SHIFT:0]};

    // ---------------- tracking state ----------------
    logic               busy_reg,       busy_next;
    logic [63:0]        cur_id_reg,     cur_id_next;
    logic [19:0]        cur_bytes_reg,  cur_bytes_next;
    logic [9:0]         cur_chunks_reg, cur_chunks_next;
    logic [9:0]         got_reg,        got_next;
    logic [EPOCH_W-1:0] epoch_reg,      epoch_next;

    // ---------------- stage a: request with bitmap read in flight ----------------
    logic              a_valid_reg;
    op_t               a_op_reg;
    logic [1:0]        a_op_raw_reg;
    logic [63:0]       a_id_reg;
    logic [19:0]       a_bytes_reg;
    logic [9:0]        a_chunks_reg;
    logic              a_img_reg;
    logic [MAP_AW-1:0] a_idx_reg;
    logic              a_pv_reg;
    logic              a_too_large_reg;
    logic              a_cnt_bad_reg;
    logic              a_idx_in_reg;
    logic              a_len_bad_reg;
    logic              a_len_full_reg;
    logic [19:0]       a_end_reg;

    logic s_acc;
    logic commit;
    logic out_free;
    logic wrap_pending;
    logic map_clearing;

    assign out_free = !m_tvalid || m_tready;
    assign commit   = a_valid_reg && out_free;
    // hold off while the request in stage a would exhaust the epochs
    assign wrap_pending = (epoch_reg == EPOCH_MAX) && a_valid_reg
                          && ((a_op_raw_reg == OP_BEGIN) || (a_op_raw_reg == OP_CLEAR));
    assign s_tready = !map_clearing && !wrap_pending && (!a_valid_reg || commit);
    assign s_acc    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_acc) begin
            a_valid_reg <= 1'b1;
        end else if (commit) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            a_op_reg        <= op_t'(s_tuser);
            a_op_raw_reg    <= s_tuser;
            a_id_reg        <= s_id;
            a_bytes_reg     <= s_bytes[19:0];
            a_chunks_reg    <= s_chunks[9:0];
            a_img_reg       <= s_img;
            a_idx_reg       <= s_idx[MAP_AW-1:0];
            a_pv_reg        <= s_pv;
            a_too_large_reg <= pre_too_large;
            a_cnt_bad_reg   <= pre_cnt_bad;
            a_idx_in_reg    <= pre_idx_in;
            a_len_bad_reg   <= pre_len_bad;
            a_len_full_reg  <= pre_len_full;
            a_end_reg       <= pre_end;
        end
    end

    // ---------------- presence bitmap ----------------
    // an entry counts as present when its tag equals the current epoch
    map_req_t           map_req;
    logic [EPOCH_W-1:0] map_tag;
    logic               mark_new;
    logic               epoch_adv;

    assign map_req.rd_en     = s_acc;
    assign map_req.rd_addr   = s_idx[MAP_AW-1:0];
    assign map_req.wr_en     = commit && mark_new;
    assign map_req.wr_addr   = a_idx_reg;
    assign map_req.clr_start = commit && epoch_adv && (epoch_reg == EPOCH_MAX);

    crt_map #(
        .EPOCH_W (EPOCH_W)
    ) u_map (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (map_req),
        .wr_tag   (epoch_reg),
        .rd_tag   (map_tag),
        .clearing (map_clearing)
    );

    // ---------------- decision for the request in stage a ----------------
    status_t     res_status;
    logic        res_wen;
    logic [18:0] res_woff;
    logic        res_done;
    logic [9:0]  idx_ext;
    logic        is_last;
    logic        id_match;
    logic [9:0]  got_inc;

    assign idx_ext  = {1'b0, a_idx_reg};
    assign is_last  = ((idx_ext + 10'd1) == cur_chunks_reg);
    assign id_match = (cur_id_reg == a_id_reg);

    always_comb begin
        res_status      = ST_OK;
        res_wen         = 1'b0;
        res_woff        = '0;
        res_done        = 1'b0;
        mark_new        = 1'b0;
        epoch_adv       = 1'b0;
        got_inc         = got_reg;
        busy_next       = busy_reg;
        cur_id_next     = cur_id_reg;
        cur_bytes_next  = cur_bytes_reg;
        cur_chunks_next = cur_chunks_reg;
        got_next        = got_reg;
        case (a_op_reg)
            OP_BEGIN: begin
                // a begin with the active id restarts the transfer
                if (busy_reg && !id_match) begin
                    res_status = ST_BUSY;
                end else if (a_too_large_reg) begin
                    res_status = ST_TOO_LARGE;
                end else if (a_cnt_bad_reg) begin
                    res_status = ST_BAD_CHUNK;
                end else if (!a_img_reg) begin
                    res_status = ST_NO_PROGRAM;
                end else begin
                    busy_next       = 1'b1;
                    cur_id_next     = a_id_reg;
                    cur_bytes_next  = a_bytes_reg;
                    cur_chunks_next = a_chunks_reg;
                    got_next        = '0;
                    epoch_adv       = 1'b1;
                end
            end
            OP_CHUNK: begin
                if (!busy_reg || !id_match) begin
                    res_status = ST_UNKNOWN;
                end else if (!a_pv_reg || !a_idx_in_reg || (idx_ext >= cur_chunks_reg)) begin
                    res_status = ST_BAD_CHUNK;
                end else if (a_len_bad_reg) begin
                    res_status = ST_BAD_CHUNK;
                end else if (a_end_reg > cur_bytes_reg) begin
                    res_status = ST_BAD_CHUNK;
                end else if (!is_last && !a_len_full_reg) begin
                    res_status = ST_BAD_CHUNK;
                end else if (is_last && (a_end_reg != cur_bytes_reg)) begin
                    res_status = ST_BAD_CHUNK;
                end else begin
                    res_wen  = 1'b1;
                    res_woff = {a_idx_reg, {CHUNK_SHIFT{1'b0}}};
                    // duplicates are written again but counted once
                    if (map_tag != epoch_reg) begin
                        mark_new = 1'b1;
                        got_inc  = got_reg + 10'd1;
                    end
                    got_next = got_inc;
                    if (got_inc >= cur_chunks_reg) begin
                        busy_next = 1'b0;
                        if (!a_img_reg) begin
                            res_status = ST_NO_PROGRAM;
                        end else begin
                            res_done = 1'b1;
                        end
                    end
                end
            end
            OP_CLEAR: begin
                busy_next       = 1'b0;
                cur_id_next     = '0;
                cur_bytes_next  = '0;
                cur_chunks_next = '0;
                got_next        = '0;
                epoch_adv       = 1'b1;
            end
            default: begin
                // unused op code leaves everything alone
                res_status = ST_OK;
            end
        endcase
    end

    // epoch wraps back to one; the sweep started alongside zeroes every tag
    assign epoch_next = (epoch_reg == EPOCH_MAX) ? EPOCH_ONE : epoch_reg + EPOCH_ONE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            cur_id_reg     <= '0;
            cur_bytes_reg  <= '0;
            cur_chunks_reg <= '0;
            got_reg        <= '0;
            epoch_reg      <= EPOCH_ONE;
        end else if (commit) begin
            busy_reg       <= busy_next;
            cur_id_reg     <= cur_id_next;
            cur_bytes_reg  <= cur_bytes_next;
            cur_chunks_reg <= cur_chunks_next;
            got_reg        <= got_next;
            if (epoch_adv) begin
                epoch_reg <= epoch_next;
            end
        end
    end

    // ---------------- result register ----------------
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_data_reg <= {6'b0, got_next, res_done, res_woff, res_wen, res_status};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ---------------- checks ----------------
    `CRT_ASSERT_IMPL(a_no_accept_in_sweep, s_tvalid && s_tready, !map_clearing, "request taken during bitmap sweep")
    `CRT_ASSERT_IMPL(a_count_below_total, busy_reg, got_reg < cur_chunks_reg, "open transfer already has all chunks")
    `CRT_ASSERT_IMPL(a_write_only_on_accept, m_tvalid && m_tdata[3], (m_tdata[2:0] == ST_OK) || (m_tdata[2:0] == ST_NO_PROGRAM), "write enable with a refusal status")
    `CRT_ASSERT_NEXT(a_done_closes, commit && res_done, !busy_reg, "transfer still open after completion")
    `CRT_ASSERT_ALWAYS(a_epoch_nonzero, epoch_reg != '0, "epoch reached the cleared tag value")

endmodule
